[rtl/core/smf_pkg.sv]
// Shared types for the sliding median filter.
package smf_pkg;

  // Control bits handed from one sorted cell to its neighbors.
  typedef struct packed {
    logic gt;        // stored value is greater than the incoming sample
    logic del_upto;  // the oldest entry sits at this cell or below
  } smf_link_t;

endpackage

[rtl/core/smf_ifs.sv]
// Valid/ready stream interfaces for the sample and median channels.
interface smf_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smf_median_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

[rtl/core/smf_cell.sv]
// One cell of the sorted window: holds a value and its age, shifts with neighbors.
module smf_cell #(
  parameter int SAMPLE_BITS = 10,
  parameter int AGE_W       = 4,
  parameter int WINDOW      = 11,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] lo_val,
  input  logic [AGE_W-1:0]       lo_age,
  input  smf_pkg::smf_link_t     lo_link,
  input  logic [SAMPLE_BITS-1:0] hi_val,
  input  logic [AGE_W-1:0]       hi_age,
  input  smf_pkg::smf_link_t     hi_link,
  output logic [SAMPLE_BITS-1:0] val,
  output logic [AGE_W-1:0]       age,
  output smf_pkg::smf_link_t     link
);
  import smf_pkg::*;

  localparam bit IS_FIRST = (INDEX == 0);
  localparam bit IS_LAST  = (INDEX == WINDOW - 1);
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);
  localparam logic [AGE_W-1:0] AGE_RESET  = AGE_W'(INDEX);

  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]       age_r, age_nxt;

  logic                   del_here;
  logic                   del_upto;
  logic                   gt_own;
  // Window with the oldest entry removed: entries at this and the previous slot.
  logic [SAMPLE_BITS-1:0] cur_val, prv_val;
  logic [AGE_W-1:0]       cur_age, prv_age;
  logic                   cur_gt, prv_gt;

  always_comb begin
    del_here = (age_r == AGE_OLDEST);
    del_upto = (IS_FIRST ? 1'b0 : lo_link.del_upto) | del_here;
    gt_own   = (val_r > sample);

    cur_val = del_upto ? hi_val : val_r;
    cur_age = del_upto ? hi_age : age_r;
    cur_gt  = IS_LAST ? 1'b1 : (del_upto ? hi_link.gt : gt_own);

    prv_val = lo_link.del_upto ? val_r : lo_val;
    prv_age = lo_link.del_upto ? age_r : lo_age;
    prv_gt  = IS_FIRST ? 1'b0 : (lo_link.del_upto ? gt_own : lo_link.gt);
  end

  always_comb begin
    if (!cur_gt) begin
      val_nxt = cur_val;
      age_nxt = cur_age + 1'b1;
    end else if (!prv_gt) begin
      // insertion point of the new sample
      val_nxt = sample;
      age_nxt = '0;
    end else begin
      val_nxt = prv_val;
      age_nxt = prv_age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= AGE_RESET;
    end else if (en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val           = val_r;
  assign age           = age_r;
  assign link.gt       = gt_own;
  assign link.del_upto = del_upto;

endmodule

[rtl/core/sliding_median_filter.sv]
// Sliding-window median filter. Each sample beat replaces the oldest of the last
// WINDOW samples (all zero after reset) and yields one median beat: the middle
// value of the window in ascending order. The window is kept sorted in a row of
// WINDOW cells; on a beat every cell moves its entry up, down or keeps it, based on
// one compare against the new sample and the position of the oldest entry, so the
// block takes one sample per cycle when not stalled, and the median appears in
// the next cycle; input stalls only while a median waits and out_ch.ready is low.
module sliding_median_filter #(
  parameter int WINDOW      = 11,
  parameter int SAMPLE_BITS = 10
) (
  input  logic clk,
  input  logic rst_n,
  smf_sample_if.sink   in_ch,
  smf_median_if.source out_ch
);
  import smf_pkg::*;

  localparam int AGE_W = $clog2(WINDOW);
  localparam int MID   = WINDOW / 2;

  logic [SAMPLE_BITS-1:0] cell_val  [WINDOW];
  logic [AGE_W-1:0]       cell_age  [WINDOW];
  smf_link_t              cell_link [WINDOW];

  logic out_valid_r, out_valid_nxt;
  logic take;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic [AGE_W-1:0]       lo_age, hi_age;
    smf_link_t              lo_link, hi_link;

    if (i == 0) begin : g_lo_edge
      assign lo_val  = '0;
      assign lo_age  = '0;
      assign lo_link = '0;
    end else begin : g_lo
      assign lo_val  = cell_val[i-1];
      assign lo_age  = cell_age[i-1];
      assign lo_link = cell_link[i-1];
    end

    if (i == WINDOW - 1) begin : g_hi_edge
      assign hi_val  = '0;
      assign hi_age  = '0;
      assign hi_link = '0;
    end else begin : g_hi
      assign hi_val  = cell_val[i+1];
      assign hi_age  = cell_age[i+1];
      assign hi_link = cell_link[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W),
      .WINDOW      (WINDOW),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (take),
      .sample  (in_ch.sample),
      .lo_val  (lo_val),
      .lo_age  (lo_age),
      .lo_link (lo_link),
      .hi_val  (hi_val),
      .hi_age  (hi_age),
      .hi_link (hi_link),
      .val     (cell_val[i]),
      .age     (cell_age[i]),
      .link    (cell_link[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Cells only change on an accepted beat, so the middle cell holds the pending median.
  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = cell_val[MID];

endmodule

[verif/testbench.sv]
// Testbench for sliding_median_filter: directed and random samples, checked against a median predictor.
module testbench;

  localparam int WINDOW      = 11;
  localparam int SAMPLE_BITS = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 20;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Window model plus the queue of medians still owed by the block.
  class median_scoreboard;
    sample_t     win_vals[WINDOW];
    int unsigned win_ages[WINDOW];
    sample_t     owed_medians[$];
    int          errors;

    function new();
      for (int i = 0; i < WINDOW; i++) begin
        win_vals[i] = '0;
        win_ages[i] = i;
      end
      errors = 0;
    endfunction

    function void note_sample(sample_t s);
      sample_t ordered[WINDOW];
      sample_t key;
      int      j;
      for (int i = 0; i < WINDOW; i++) begin
        if (win_ages[i] >= WINDOW - 1) begin
          win_vals[i] = s;
          win_ages[i] = 0;
        end else begin
          win_ages[i] = win_ages[i] + 1;
        end
      end
      ordered = win_vals;
      for (int i = 1; i < WINDOW; i++) begin
        key = ordered[i];
        j   = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      owed_medians.push_back(ordered[WINDOW/2]);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_median(sample_t got);
      sample_t want;
      if (owed_medians.size() == 0) begin
        report($sformatf("median beat %0d with none outstanding", got));
        return;
      end
      want = owed_medians.pop_front();
      if (got !== want)
        report($sformatf("median got %0d, want %0d", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;

  smf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  smf_median_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  sliding_median_filter #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  median_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_asked;
  int hold_served;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Outputs are checked before the input beat of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_median(out_ch.median);
      if (in_ch.valid && in_ch.ready)
        sb.note_sample(in_ch.sample);
    end
  end

  task send_sample(sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task run_phase(int count, int idle, int stall, bit long_hold);
    sample_t level;
    sample_t s;
    idle_pct  = idle;
    stall_pct = stall;
    if (long_hold)
      hold_asked++;
    level = sample_t'($urandom_range(1023));
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(7))
        0:       s = '0;
        1:       s = '1;
        // clustered values make ties and slow drifts
        2, 3:    s = level + sample_t'($urandom_range(7));
        default: s = sample_t'($urandom_range(1023));
      endcase
      if ($urandom_range(31) == 0)
        level = sample_t'($urandom_range(1023));
      send_sample(s);
    end
  endtask

  initial begin
    sample_t directed[$];
    sb          = new();
    hold_asked  = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Start-up zeros still win the median, then a run of max takes it over,
    // then the zeros flush back in; equal values close it out.
    directed = '{10'd1023, 10'd1023, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512};
    repeat (8) directed.push_back(10'd1023);
    repeat (6) directed.push_back(10'd0);
    repeat (3) directed.push_back(10'd5);
    foreach (directed[i])
      send_sample(directed[i]);

    run_phase(90, 0, 0, 1'b0);
    run_phase(90, 48, 0, 1'b0);
    run_phase(90, 0, 48, 1'b0);
    run_phase(90, 33, 33, 1'b0);
    run_phase(60, 0, 0, 1'b1);
    run_phase(40, 33, 33, 1'b0);

    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (sb.owed_medians.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
